FILE: rtl/core/scancode_text_console_macros.svh
// Assertion macros shared by the console checker.
`ifndef SCANCODE_TEXT_CONSOLE_MACROS_SVH
`define SCANCODE_TEXT_CONSOLE_MACROS_SVH

// Check that a condition implies another in the same cycle.
`define SCTC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that a condition implies another in the next cycle.
`define SCTC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/sctc_pkg.sv
// Shared constants, key table and types for the scancode text console.
`timescale 1ns / 1ps

package sctc_pkg;

	localparam int SCREEN_COLUMNS = 80;
	localparam int SCREEN_ROWS    = 25;
	localparam int LINE_CAPACITY  = 256;

	localparam int COL_W  = 8;
	localparam int ROW_W  = 5;
	localparam int ADDR_W = 11;
	localparam int PROD_W = 16;

	// Register indexes on the configuration channel
	localparam logic CFG_ATTR   = 1'b0;
	localparam logic CFG_PROMPT = 1'b1;

	localparam logic [7:0] SC_ENTER     = 8'h1C;
	localparam logic [7:0] SC_BACKSPACE = 8'h0E;
	localparam logic [7:0] SPACE_CHAR   = 8'h20;

	// Printable character per make code 0x00..0x3F; zero marks no character
	localparam logic [7:0] KEY_CHARS [64] = '{
		8'h00, 8'h00, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
		8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h3D, 8'h00, 8'h09,
		8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
		8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h00, 8'h00, 8'h61, 8'h73,
		8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
		8'h27, 8'h00, 8'h00, 8'h00, 8'h7A, 8'h78, 8'h63, 8'h76,
		8'h62, 8'h6E, 8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h00,
		8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
	};

	typedef enum logic [1:0] {
		CLS_NONE,
		CLS_PRINT,
		CLS_ENTER,
		CLS_BKSP
	} key_class_t;

	typedef struct packed {
		key_class_t  kind;
		logic [7:0]  chr;
	} key_info_t;

	typedef struct packed {
		logic              cell_write;
		logic [ADDR_W-1:0] cell_address;
		logic [7:0]        cell_char;
		logic [7:0]        cell_attr;
		logic              char_stored;
		logic [7:0]        line_index;
		logic              line_done;
		logic [7:0]        line_length;
	} result_t;

endpackage

FILE: rtl/core/sctc_keymap.sv
// Scancode classifier: maps a set-1 byte to a key class and character.
`timescale 1ns / 1ps

module sctc_keymap (
	input  logic [7:0]         scancode,
	output sctc_pkg::key_info_t key
);
	import sctc_pkg::*;

	logic [7:0] chr;

	// Look up the character for make codes below 0x40
	assign chr = KEY_CHARS[scancode[5:0]];

	// Classify: releases and high codes drop out, printable keys first
	always_comb begin
		key.chr  = 8'h00;
		key.kind = CLS_NONE;
		if (scancode[7:6] == 2'b00) begin
			if (chr != 8'h00) begin
				key.kind = CLS_PRINT;
				key.chr  = chr;
			end else if (scancode == SC_ENTER) begin
				key.kind = CLS_ENTER;
			end else if (scancode == SC_BACKSPACE) begin
				key.kind = CLS_BKSP;
			end
		end
	end

endmodule

FILE: rtl/core/sctc_engine.sv
// Cursor, line count and result forming for one classified key.
`timescale 1ns / 1ps

module sctc_engine (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                advance,
	input  sctc_pkg::key_info_t key,
	input  logic [7:0]          text_attribute,
	input  logic [6:0]          prompt_column,
	output sctc_pkg::result_t   result
);
	import sctc_pkg::*;

	localparam logic [8:0] LINE_LIMIT = 9'(LINE_CAPACITY - 1);

	logic [COL_W-1:0]  cursor_column_q, column_d;
	logic [ROW_W-1:0]  cursor_row_q, row_d, row_next, addr_row;
	logic [ROW_W:0]    row_inc;
	logic [7:0]        line_count_q, count_d;
	logic              col_wrap;
	logic [COL_W-1:0]  col_w, addr_col;
	logic [ROW_W-1:0]  row_w;
	logic [PROD_W-1:0] addr_full;

	// Next row with wrap to the top
	assign row_inc  = {1'b0, cursor_row_q} + (ROW_W+1)'(1);
	assign row_next = (row_inc >= (ROW_W+1)'(SCREEN_ROWS)) ? '0 : row_inc[ROW_W-1:0];

	// Wrap the cursor before a character lands
	assign col_wrap = cursor_column_q >= COL_W'(SCREEN_COLUMNS);
	assign col_w    = col_wrap ? '0 : cursor_column_q;
	assign row_w    = col_wrap ? row_next : cursor_row_q;

	// Pick the cell: printable at the wrapped cursor, erase one column back
	assign addr_row  = (key.kind == CLS_PRINT) ? row_w : cursor_row_q;
	assign addr_col  = (key.kind == CLS_PRINT) ? col_w : cursor_column_q - COL_W'(1);
	assign addr_full = PROD_W'(addr_row) * PROD_W'(SCREEN_COLUMNS) + PROD_W'(addr_col);

	// Form the result and the next state
	always_comb begin
		result   = '0;
		column_d = cursor_column_q;
		row_d    = cursor_row_q;
		count_d  = line_count_q;
		case (key.kind)
			CLS_PRINT: begin
				if ({1'b0, line_count_q} < LINE_LIMIT) begin
					result.cell_write   = 1'b1;
					result.cell_address = addr_full[ADDR_W-1:0];
					result.cell_char    = key.chr;
					result.cell_attr    = text_attribute;
					result.char_stored  = 1'b1;
					result.line_index   = line_count_q;
					count_d             = line_count_q + 8'd1;
					column_d            = col_w + COL_W'(1);
					row_d               = row_w;
				end
			end
			CLS_ENTER: begin
				result.line_done   = 1'b1;
				result.line_length = line_count_q;
				count_d            = '0;
				row_d              = row_next;
				column_d           = COL_W'(prompt_column);
			end
			CLS_BKSP: begin
				if (line_count_q != 8'd0) begin
					count_d = line_count_q - 8'd1;
					if (cursor_column_q != '0) begin
						column_d            = addr_col;
						result.cell_write   = 1'b1;
						result.cell_address = addr_full[ADDR_W-1:0];
						result.cell_char    = SPACE_CHAR;
						result.cell_attr    = text_attribute;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// Commit the state when the item moves to the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_column_q <= '0;
			cursor_row_q    <= '0;
			line_count_q    <= '0;
		end else if (advance) begin
			cursor_column_q <= column_d;
			cursor_row_q    <= row_d;
			line_count_q    <= count_d;
		end
	end

endmodule

FILE: rtl/core/scancode_text_console.sv
// Throughput: one scancode per cycle while out_ready holds; an accepted
// scancode passes the input register, one pass of cursor logic and the
// result register, with ready flowing back through both stages.
// Reset: cursor, line count and stage valids clear; text_attribute returns to
// 15 and prompt_column to 8. No clearing pass.
`timescale 1ns / 1ps

module scancode_text_console (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [7:0]                    scancode,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          cell_write,
	output logic [sctc_pkg::ADDR_W-1:0]   cell_address,
	output logic [7:0]                    cell_char,
	output logic [7:0]                    cell_attr,
	output logic                          char_stored,
	output logic [7:0]                    line_index,
	output logic                          line_done,
	output logic [7:0]                    line_length,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic                          cfg_index,
	input  logic [7:0]                    cfg_data
);
	import sctc_pkg::*;

	logic        valid_s1, valid_s2;
	key_info_t   key_in, key_s1;
	result_t     result, result_s2;
	logic        load_s2, advance;
	logic [7:0]  text_attribute_q;
	logic [6:0]  prompt_column_q;

	// Classify the incoming byte ahead of the input register
	sctc_keymap u_keymap (
		.scancode (scancode),
		.key      (key_in)
	);

	// Handshake: result register frees when empty or taken
	assign load_s2   = !valid_s2 || out_ready;
	assign advance   = valid_s1 && load_s2;
	assign in_ready  = !valid_s1 || load_s2;
	assign cfg_ready = 1'b1;

	// Hold the configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_attribute_q <= 8'd15;
			prompt_column_q  <= 7'd8;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_ATTR:   text_attribute_q <= cfg_data;
				CFG_PROMPT: prompt_column_q  <= cfg_data[6:0];
				default: begin
				end
			endcase
		end
	end

	// Input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			key_s1 <= key_in;
		end
	end

	sctc_engine u_engine (
		.clk            (clk),
		.arst_n         (arst_n),
		.advance        (advance),
		.key            (key_s1),
		.text_attribute (text_attribute_q),
		.prompt_column  (prompt_column_q),
		.result         (result)
	);

	// Result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result;
		end
	end

	assign out_valid    = valid_s2;
	assign cell_write   = result_s2.cell_write;
	assign cell_address = result_s2.cell_address;
	assign cell_char    = result_s2.cell_char;
	assign cell_attr    = result_s2.cell_attr;
	assign char_stored  = result_s2.char_stored;
	assign line_index   = result_s2.line_index;
	assign line_done    = result_s2.line_done;
	assign line_length  = result_s2.line_length;

endmodule

FILE: rtl/core/sctc_checker.sv
// Port-level checker for the scancode text console, bound to the top level.
`timescale 1ns / 1ps
`include "scancode_text_console_macros.svh"

module sctc_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic                        cell_write,
	input logic [sctc_pkg::ADDR_W-1:0] cell_address,
	input logic [7:0]                  cell_char,
	input logic [7:0]                  cell_attr,
	input logic                        char_stored,
	input logic [7:0]                  line_index,
	input logic                        line_done,
	input logic [7:0]                  line_length
);
	import sctc_pkg::*;

	// A stalled result must hold its address
	`SCTC_ASSERT_NEXT(a_hold_addr, out_valid && !out_ready, out_valid && $stable(cell_address), "stalled result changed")

	// Unused cell fields stay zero
	`SCTC_ASSERT_NOW(a_idle_cell, out_valid && !cell_write, cell_address == '0 && cell_char == 8'd0 && cell_attr == 8'd0, "cell fields set without a write")

	// A stored character is always written to the screen
	`SCTC_ASSERT_NOW(a_store_write, out_valid && char_stored, cell_write && cell_char != 8'd0, "stored character not written")

	// Enter writes nothing and stores nothing
	`SCTC_ASSERT_NOW(a_enter_alone, out_valid && line_done, !cell_write && !char_stored && line_index == 8'd0, "enter mixed with a write")

	// Length reported only with the end of a line
	`SCTC_ASSERT_NOW(a_len_zero, out_valid && !line_done, line_length == 8'd0, "line length without enter")

endmodule

bind scancode_text_console sctc_checker u_sctc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.cell_write   (cell_write),
	.cell_address (cell_address),
	.cell_char    (cell_char),
	.cell_attr    (cell_attr),
	.char_stored  (char_stored),
	.line_index   (line_index),
	.line_done    (line_done),
	.line_length  (line_length)
);
